// ----- rtl/ctsi_pkg.sv -----
package ctsi_pkg;

  localparam int unsigned CURVES_DEF = 8;
  localparam int unsigned POINTS_DEF = 32;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned LBL_W = 8;

  // magnitude of (query - ka) * (vb - va)
  localparam int unsigned PROD_W = 2 * (KEY_W + 1);
  localparam int unsigned NUM_W  = PROD_W - 1;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 1;

  typedef enum logic [2:0] {
    MODE_WRITE       = 3'd0,
    MODE_STEP_LOSS   = 3'd1,
    MODE_STEP_MAG    = 3'd2,
    MODE_INV_KEY     = 3'd3,
    MODE_LABEL       = 3'd4,
    MODE_INTERP_LOSS = 3'd5,
    MODE_INTERP_MAG  = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RES,
    ST_LAST,
    ST_SCAN,
    ST_DIVS,
    ST_DIVW,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [LBL_W-1:0] label;
    logic [VAL_W-1:0] magnet;
    logic [VAL_W-1:0] loss;
    logic [KEY_W-1:0] key;
  } point_t;

endpackage

// ----- rtl/ctsi_div.sv -----
module ctsi_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ctsi_pkg::NUM_W-1:0] dividend_i,
  input  logic [ctsi_pkg::KEY_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [ctsi_pkg::NUM_W-1:0] quot_o
);
  import ctsi_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [KEY_W-1:0] rem_q;
  logic [KEY_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [KEY_W:0]   rem_sh;
  logic [KEY_W:0]   rem_nx;
  logic             ge;

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_nx[KEY_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/curve_table_step_and_interp_lookup.sv -----
// Breakpoint curve table: CURVES curves of up to POINTS points, each point a
// key, a loss value, a magnetizing value and a label, all held in one
// single-port-read synchronous memory.
// Requests enter on the s_axis channel (tuser carries the mode), results
// leave on m_axis (tuser carries found), one result per request.
// A write request stores the point and sets the curve count.
// Step, inverse and label requests run a binary search, each probe a memory
// read, then a compare. Interpolating requests read both ends, then scan the
// keys one per cycle, then run a bit-serial divide. One request is worked on
// at a time.
// A new request is taken while the previous result still waits in the output
// register; if the receiver stalls, the finished result holds in the block
// and s_axis_tready stays low until the output register frees up.
// Reset clears the point counts of all curves and the output valid; the point
// memory itself is not cleared, a point reads back only after it is written.
module curve_table_step_and_interp_lookup #(
  parameter int unsigned CURVES = ctsi_pkg::CURVES_DEF,
  parameter int unsigned POINTS = ctsi_pkg::POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // curve_sel[2:0], slot[7:3], query_key[23:8], loss_in[39:24],
  // magnet_in[55:40], label_in[63:56]
  input  logic [ctsi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode[2:0]
  input  logic [ctsi_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // value_out[15:0], label_out[23:16]
  output logic [ctsi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // found[0]
  output logic [ctsi_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import ctsi_pkg::*;

  localparam int unsigned CW    = (CURVES > 1) ? $clog2(CURVES) : 1;
  localparam int unsigned PW    = $clog2(POINTS);
  localparam int unsigned NW    = $clog2(POINTS + 1);
  localparam int unsigned AW    = CW + PW;
  localparam int unsigned DEPTH = CURVES * (2 ** PW);

  // input unpacking
  logic [2:0]       in_curve;
  logic [4:0]       in_slot;
  logic [KEY_W-1:0] in_key;
  point_t           wr_row;
  logic             curve_ok;
  logic             slot_ok;

  assign in_curve = s_axis_tdata[2:0];
  assign in_slot  = s_axis_tdata[7:3];
  assign in_key   = s_axis_tdata[23:8];
  assign wr_row   = point_t'(s_axis_tdata[63:8]);
  assign curve_ok = 32'(in_curve) < CURVES;
  assign slot_ok  = 32'(in_slot) < POINTS;

  // point memory
  point_t        mem [DEPTH];
  point_t        rdata_q;
  logic          mem_we;
  logic          mem_re;
  logic [PW-1:0] rd_pt;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // point counts
  logic [NW-1:0] pcnt_q [CURVES];
  logic          pcnt_we;

  state_e state_q, state_d;
  logic [2:0]        mode_q, mode_d;
  logic [CW-1:0]     curve_q, curve_d;
  logic [KEY_W-1:0]  qry_q, qry_d;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     first_q, first_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [NW-1:0]     idx_q, idx_d;
  logic [KEY_W-1:0]  prev_key_q, prev_key_d;
  logic [VAL_W-1:0]  prev_val_q, prev_val_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [KEY_W-1:0]  den_q, den_d;
  logic [VAL_W-1:0]  va_q, va_d;
  logic              res_found_q, res_found_d;
  logic [VAL_W-1:0]  res_val_q, res_val_d;
  logic [LBL_W-1:0]  res_lbl_q, res_lbl_d;

  logic              m_valid_q;
  logic              m_found_q;
  logic [VAL_W-1:0]  m_val_q;
  logic [LBL_W-1:0]  m_lbl_q;
  logic              out_load;

  logic              accept;
  logic              interp_mode;
  logic [KEY_W-1:0]  col;
  logic [VAL_W-1:0]  v_rd;
  logic [NW-1:0]     half;
  logic [NW-1:0]     pos;
  logic signed [KEY_W:0] dk;
  logic signed [KEY_W:0] dv;
  logic [PROD_W-1:0] prod_mag;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign interp_mode = (mode_q == MODE_INTERP_LOSS) || (mode_q == MODE_INTERP_MAG);
  // inverse mode searches the loss column
  assign col         = (mode_q == MODE_INV_KEY) ? rdata_q.loss : rdata_q.key;
  assign v_rd        = (mode_q == MODE_INTERP_LOSS) ? rdata_q.loss : rdata_q.magnet;
  assign half        = cnt_q >> 1;
  assign pos         = first_q + half;
  assign dk          = $signed({1'b0, qry_q}) - $signed({1'b0, prev_key_q});
  assign dv          = $signed({1'b0, v_rd}) - $signed({1'b0, prev_val_q});
  assign prod_mag    = prod_q[PROD_W-1] ? (~prod_q + PROD_W'(1)) : prod_q;

  assign wr_addr = {CW'(in_curve), PW'(in_slot)};
  // the first read is issued while the curve of the new request is taken
  assign rd_addr = {curve_d, rd_pt};
  assign pcnt_we = accept && (s_axis_tuser == MODE_WRITE) && curve_ok && slot_ok;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE);

  ctsi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag[NUM_W-1:0]),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CURVES; c++) begin
        pcnt_q[c] <= '0;
      end
    end else if (pcnt_we) begin
      pcnt_q[CW'(in_curve)] <= NW'(in_slot) + NW'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    curve_d     = curve_q;
    qry_d       = qry_q;
    n_d         = n_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    prev_key_d  = prev_key_q;
    prev_val_d  = prev_val_q;
    prod_d      = prod_q;
    den_d       = den_q;
    va_d        = va_q;
    res_found_d = res_found_q;
    res_val_d   = res_val_q;
    res_lbl_d   = res_lbl_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_pt       = '0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d      = s_axis_tuser;
          curve_d     = CW'(in_curve);
          qry_d       = in_key;
          n_d         = pcnt_q[CW'(in_curve)];
          res_found_d = 1'b0;
          res_val_d   = '0;
          res_lbl_d   = '0;
          if (!curve_ok || (s_axis_tuser > MODE_INTERP_MAG)) begin
            state_d = ST_OUT;
          end else if (s_axis_tuser == MODE_WRITE) begin
            mem_we      = slot_ok;
            res_found_d = slot_ok;
            state_d     = ST_OUT;
          end else if (pcnt_q[CW'(in_curve)] == '0) begin
            state_d = ST_OUT;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (interp_mode) begin
          if (qry_q <= rdata_q.key) begin
            res_found_d = 1'b1;
            res_val_d   = v_rd;
            state_d     = ST_OUT;
          end else begin
            prev_key_d = rdata_q.key;
            prev_val_d = v_rd;
            mem_re     = 1'b1;
            rd_pt      = PW'(n_q - NW'(1));
            state_d    = ST_LAST;
          end
        end else if (qry_q < col) begin
          state_d = ST_OUT;
        end else begin
          first_d = '0;
          cnt_d   = n_q;
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (cnt_q == '0) begin
          if (first_q == '0) begin
            state_d = ST_OUT;
          end else begin
            mem_re  = 1'b1;
            rd_pt   = PW'(first_q - NW'(1));
            state_d = ST_RES;
          end
        end else begin
          mem_re  = 1'b1;
          rd_pt   = PW'(pos);
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (!(qry_q < col)) begin
          first_d = pos + NW'(1);
          cnt_d   = cnt_q - half - NW'(1);
        end else begin
          cnt_d = half;
        end
        state_d = ST_SRCH_RD;
      end
      ST_RES: begin
        res_found_d = 1'b1;
        priority if (mode_q == MODE_STEP_LOSS) begin
          res_val_d = rdata_q.loss;
        end else if (mode_q == MODE_STEP_MAG) begin
          res_val_d = rdata_q.magnet;
        end else if (mode_q == MODE_INV_KEY) begin
          res_val_d = rdata_q.key;
        end else begin
          res_lbl_d = rdata_q.label;
        end
        state_d = ST_OUT;
      end
      ST_LAST: begin
        if (qry_q >= rdata_q.key) begin
          res_found_d = 1'b1;
          res_val_d   = v_rd;
          state_d     = ST_OUT;
        end else begin
          idx_d   = NW'(1);
          mem_re  = 1'b1;
          rd_pt   = PW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (qry_q <= rdata_q.key) begin
          if (rdata_q.key <= prev_key_q) begin
            // keys not ascending here: hold the lower point
            res_found_d = 1'b1;
            res_val_d   = prev_val_q;
            state_d     = ST_OUT;
          end else begin
            prod_d  = dk * dv;
            den_d   = rdata_q.key - prev_key_q;
            va_d    = prev_val_q;
            state_d = ST_DIVS;
          end
        end else begin
          prev_key_d = rdata_q.key;
          prev_val_d = v_rd;
          if ((idx_q + NW'(1)) < n_q) begin
            idx_d  = idx_q + NW'(1);
            mem_re = 1'b1;
            rd_pt  = PW'(idx_q + NW'(1));
          end else begin
            res_found_d = 1'b1;
            res_val_d   = v_rd;
            state_d     = ST_OUT;
          end
        end
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          res_found_d = 1'b1;
          // quotient truncated toward zero, sign applied after the divide
          res_val_d   = prod_q[PROD_W-1] ? (va_q - div_quot[VAL_W-1:0])
                                         : (va_q + div_quot[VAL_W-1:0]);
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    curve_q     <= curve_d;
    qry_q       <= qry_d;
    n_q         <= n_d;
    first_q     <= first_d;
    cnt_q       <= cnt_d;
    idx_q       <= idx_d;
    prev_key_q  <= prev_key_d;
    prev_val_q  <= prev_val_d;
    prod_q      <= prod_d;
    den_q       <= den_d;
    va_q        <= va_d;
    res_found_q <= res_found_d;
    res_val_q   <= res_val_d;
    res_lbl_q   <= res_lbl_d;
    if (out_load) begin
      m_found_q <= res_found_q;
      m_val_q   <= res_val_q;
      m_lbl_q   <= res_lbl_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_lbl_q, m_val_q};
  assign m_axis_tuser  = m_found_q;

endmodule
